// ===== sv/rbps_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rbps_pkg
// Shared types, codes and helpers of the ready bitmap priority scheduler.
// -----------------------------------------------------------------------------
package rbps_pkg;

	localparam int NUM_PRIOS_DEF = 256;
	localparam int WORD_BITS     = 32;
	localparam int PRIO_W        = 8;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_ENABLE  = 2'd1,
		CMD_DISABLE = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_code_t;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [1:0]        command;
		logic [PRIO_W-1:0] prio;
		logic [PRIO_W-1:0] current_prio;
	} cmd_item_t;

	typedef struct packed {
		logic              status;
		logic              yield_request;
		logic              prio_created;
		logic              highest_valid;
		logic [PRIO_W-1:0] highest_prio;
	} res_item_t;

	// Per-command outcome from the bitmap update
	typedef struct packed {
		logic status;
		logic yield_request;
		logic prio_created;
	} flags_t;

	// Position of the highest set bit of a 32-bit word, 0 when the word is empty
	function automatic logic [4:0] lead_one32(input logic [31:0] x);
		logic [31:0] v;
		logic [4:0]  n;
		begin
			v = x;
			n = 5'd0;
			if (v[31:16] == 16'h0) begin
				n = n + 5'd16;
				v = v << 16;
			end
			if (v[31:24] == 8'h0) begin
				n = n + 5'd8;
				v = v << 8;
			end
			if (v[31:28] == 4'h0) begin
				n = n + 5'd4;
				v = v << 4;
			end
			if (v[31:30] == 2'h0) begin
				n = n + 5'd2;
				v = v << 2;
			end
			if (v[31] == 1'b0) begin
				n = n + 5'd1;
			end
			return 5'd31 - n;
		end
	endfunction

endpackage

// ===== sv/rbps_stream_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rbps_stream_if
// Valid/ready channel carrying one item of a given payload type.
// -----------------------------------------------------------------------------
interface rbps_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rbps_bitmap.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rbps_bitmap
// Created and ready bitmaps with group bits; decodes one command and updates.
// -----------------------------------------------------------------------------
module rbps_bitmap #(
	parameter int NUM_PRIOS = rbps_pkg::NUM_PRIOS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  rbps_pkg::cmd_item_t                     item,
	output logic [((NUM_PRIOS+31)/32)*32-1:0]       ready_next,
	output logic [(NUM_PRIOS+31)/32-1:0]            group_next,
	output rbps_pkg::flags_t                        flags
);
	import rbps_pkg::*;

	localparam int WORDS = (NUM_PRIOS + 31) / 32;
	localparam int BITS  = WORDS * WORD_BITS;
	localparam int BIT_W = $clog2(BITS);

	logic [BITS-1:0]  created_q, created_d;
	logic [BITS-1:0]  ready_q, ready_d;
	logic [WORDS-1:0] group_q, group_d;
	logic [WORDS-1:0] word_hit;
	logic [WORDS-1:0] word_nz;
	logic [BIT_W-1:0] bit_idx;
	logic [BITS-1:0]  bit_mask;
	logic             in_range;
	logic             exists;
	logic             clr_group;
	flags_t           flags_d;

	assign in_range = int'(item.prio) < NUM_PRIOS;
	assign bit_idx  = BIT_W'(item.prio);
	assign bit_mask = BITS'(1) << bit_idx;
	assign exists   = created_q[bit_idx];

	always_comb begin
		for (int i = 0; i < WORDS; i++) begin
			word_hit[i] = (bit_idx >> 5) == BIT_W'(i);
			word_nz[i]  = |ready_q[i*WORD_BITS +: WORD_BITS];
		end
	end

	always_comb begin
		created_d             = created_q;
		ready_d               = ready_q;
		group_d               = group_q;
		clr_group             = 1'b0;
		flags_d.status        = STATUS_OK;
		flags_d.yield_request = 1'b0;
		if (!in_range) begin
			flags_d.status = STATUS_INVALID;
		end else begin
			case (cmd_code_t'(item.command))
				CMD_CREATE: begin
					if (exists) begin
						flags_d.status = STATUS_INVALID;
					end else begin
						created_d = created_q | bit_mask;
						ready_d   = ready_q | bit_mask;
						group_d   = group_q | word_hit;
					end
				end
				CMD_ENABLE: begin
					if (!exists) begin
						flags_d.status = STATUS_INVALID;
					end else begin
						ready_d = ready_q | bit_mask;
						group_d = group_q | word_hit;
					end
				end
				CMD_DISABLE: begin
					if (!exists) begin
						flags_d.status = STATUS_INVALID;
					end else if (item.prio == item.current_prio) begin
						flags_d.yield_request = 1'b1;
					end else begin
						ready_d   = ready_q & ~bit_mask;
						clr_group = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		// drop the group bit only once its word has emptied
		for (int i = 0; i < WORDS; i++) begin
			if (clr_group && word_hit[i] && !(|ready_d[i*WORD_BITS +: WORD_BITS])) begin
				group_d[i] = 1'b0;
			end
		end
		flags_d.prio_created = in_range && created_d[bit_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= '0;
			ready_q   <= '0;
			group_q   <= '0;
		end else if (en) begin
			created_q <= created_d;
			ready_q   <= ready_d;
			group_q   <= group_d;
		end
	end

	assign ready_next = ready_d;
	assign group_next = group_d;
	assign flags      = flags_d;

	a_group_tracks_words: assert property (@(posedge clk) disable iff (!arst_n)
		group_q == word_nz)
		else $error("group bits out of step with ready words");

	a_ready_needs_created: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q & ~created_q) == '0)
		else $error("ready bit set for a priority never created");

endmodule

// ===== sv/rbps_encode.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rbps_encode
// Two-level leading-one encode: highest non-empty group, then its top bit.
// -----------------------------------------------------------------------------
module rbps_encode #(
	parameter int NUM_PRIOS = rbps_pkg::NUM_PRIOS_DEF
) (
	input  logic [((NUM_PRIOS+31)/32)*32-1:0] ready_bits,
	input  logic [(NUM_PRIOS+31)/32-1:0]      group,
	output logic                              highest_valid,
	output logic [rbps_pkg::PRIO_W-1:0]       highest_prio
);
	import rbps_pkg::*;

	localparam int WORDS = (NUM_PRIOS + 31) / 32;
	localparam int GW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [4:0]       word_pos [WORDS];
	logic [WORDS-1:0] word_nz;
	logic [4:0]       grp_idx;
	logic [GW-1:0]    grp_sel;
	logic             any_grp;

	always_comb begin
		for (int i = 0; i < WORDS; i++) begin
			word_pos[i] = lead_one32(ready_bits[i*WORD_BITS +: WORD_BITS]);
			word_nz[i]  = |ready_bits[i*WORD_BITS +: WORD_BITS];
		end
	end

	assign any_grp = |group;
	assign grp_idx = lead_one32(32'(group));
	assign grp_sel = grp_idx[GW-1:0];

	assign highest_valid = any_grp && word_nz[grp_sel];
	assign highest_prio  = highest_valid ? PRIO_W'({grp_idx, word_pos[grp_sel]}) : '0;

endmodule

// ===== sv/ready_bitmap_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ready_bitmap_priority_scheduler_top
// Command front end of the two-level bitmap priority scheduler.
// -----------------------------------------------------------------------------
// A command is held in the input register and then in the result register; it
// stays in the input register while an earlier result waits for res.ready.
// Throughput: one command per cycle while res.ready is high; the bitmap update
// and the leading-one encode of the updated ready bitmap sit between the two registers.
// Reset: arst_n clears the created, ready and group bitmaps and both pipeline
// valids at once; no task exists until a create command arrives.
module ready_bitmap_priority_scheduler_top #(
	parameter int NUM_PRIOS = rbps_pkg::NUM_PRIOS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rbps_stream_if.sink   cmd,
	rbps_stream_if.source res
);
	import rbps_pkg::*;

	localparam int WORDS = (NUM_PRIOS + 31) / 32;
	localparam int BITS  = WORDS * WORD_BITS;

	logic             valid_s1;
	cmd_item_t        item_s1;
	logic             res_valid_q;
	res_item_t        res_q;
	logic             advance;
	logic             fire;
	logic [BITS-1:0]  ready_next;
	logic [WORDS-1:0] group_next;
	flags_t           flags;
	logic             highest_valid;
	logic [PRIO_W-1:0] highest_prio;

	assign advance   = !res_valid_q || res.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	rbps_bitmap #(
		.NUM_PRIOS (NUM_PRIOS)
	) u_bitmap (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire),
		.item       (item_s1),
		.ready_next (ready_next),
		.group_next (group_next),
		.flags      (flags)
	);

	rbps_encode #(
		.NUM_PRIOS (NUM_PRIOS)
	) u_encode (
		.ready_bits    (ready_next),
		.group         (group_next),
		.highest_valid (highest_valid),
		.highest_prio  (highest_prio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.status        <= flags.status;
			res_q.yield_request <= flags.yield_request;
			res_q.prio_created  <= flags.prio_created;
			res_q.highest_valid <= highest_valid;
			res_q.highest_prio  <= highest_prio;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_q)
		else $error("item left the input stage without a result");

	a_yield_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.yield_request |-> res_q.status == STATUS_OK
			&& res_q.prio_created)
		else $error("yield request on a failed command");

	a_idle_prio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.highest_valid |-> res_q.highest_prio == '0)
		else $error("highest priority nonzero with nothing ready");

endmodule
